// ----- rtl/line_follow_pd_steering_core_assert.svh -----
// ---------------------------------------------------------------------------
// line_follow_pd_steering_core_assert.svh
// Assertion macros used by the PD steering top level.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PD_STEERING_CORE_ASSERT_SVH
`define LINE_FOLLOW_PD_STEERING_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFPD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lfpd_pkg.sv -----
// ---------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, register indexes, constants and types of the PD steering core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfpd_pkg;

  localparam int DUTY_BITS  = 8;   // duty register width, 8..16
  localparam int POS_W      = 4;
  localparam int GAIN_W     = 8;
  localparam int ERR_W      = 5;   // error spans -15..15
  localparam int DIFF_W     = 6;   // error difference spans -30..30
  localparam int DERIV_W    = 3;   // derivative spans -3..3
  localparam int DRIVE_W    = 14;  // |drive| <= 4590
  localparam int CALC_W     = 17;  // base - 2*|drive|, wraps to the duty width
  localparam int BASE_W     = 7;
  localparam int OUT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV  = 2'd2;

  localparam logic [DIFF_W-1:0]         DIFF_DIVISOR = 6'd10;
  localparam logic [BASE_W-1:0]         TURN_SPEED   = 7'd40;
  localparam logic [BASE_W-1:0]         BASE_RESET   = 7'd80;
  localparam logic signed [POS_W-1:0]   TARGET_RESET = 4'sd0;
  localparam logic [GAIN_W-1:0]         PROP_RESET   = 8'd3;
  localparam logic [GAIN_W-1:0]         DERIV_RESET  = 8'd20;

  typedef struct packed {
    logic signed [POS_W-1:0] target;
    logic [GAIN_W-1:0]       prop;
    logic [GAIN_W-1:0]       deriv;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [CALC_W-1:0]       delta;     // 2*|drive|
    logic                    drive_nz;
  } law_t;

  // Difference / 10 truncated toward zero; |d| <= 30 so a compare ladder does it.
  function automatic logic signed [DERIV_W-1:0] div10(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0]       mag;
    logic signed [DERIV_W-1:0] q;
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    if (mag >= DIFF_W'(DIFF_DIVISOR * 3))      q = 3'sd3;
    else if (mag >= DIFF_W'(DIFF_DIVISOR * 2)) q = 3'sd2;
    else if (mag >= DIFF_DIVISOR)              q = 3'sd1;
    else                                       q = 3'sd0;
    return d[DIFF_W-1] ? DERIV_W'(-q) : q;
  endfunction

endpackage

// ----- rtl/lfpd_if.sv -----
// ---------------------------------------------------------------------------
// lfpd_if
// Valid/ready channels: position samples in, duty pairs out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfpd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lfpd_pkg::POS_W-1:0]    line_position;

  modport source (output valid, output line_position, input ready);
  modport sink   (input valid, input line_position, output ready);
endinterface

interface lfpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [lfpd_pkg::OUT_W-1:0]   left_duty;
  logic [lfpd_pkg::OUT_W-1:0]   right_duty;

  modport source (output valid, output left_duty, output right_duty, input ready);
  modport sink   (input valid, input left_duty, input right_duty, output ready);
endinterface

// ----- rtl/lfpd_cfg.sv -----
// ---------------------------------------------------------------------------
// lfpd_cfg
// Configuration registers: setpoint and the two gains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfpd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output lfpd_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target <= lfpd_pkg::TARGET_RESET;
      cfg.prop   <= lfpd_pkg::PROP_RESET;
      cfg.deriv  <= lfpd_pkg::DERIV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfpd_pkg::REG_TARGET: cfg.target <= cfg_data[lfpd_pkg::POS_W-1:0];
        lfpd_pkg::REG_PROP:   cfg.prop   <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_DERIV:  cfg.deriv  <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// ----- rtl/lfpd_law.sv -----
// ---------------------------------------------------------------------------
// lfpd_law
// PD control law: error, scaled derivative, drive and the duty correction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfpd_law (
  input  logic signed [lfpd_pkg::POS_W-1:0]  pos,
  input  lfpd_pkg::cfg_t                     cfg,
  input  logic signed [lfpd_pkg::ERR_W-1:0]  last_err,
  output lfpd_pkg::law_t                     law
);

  localparam int EW = lfpd_pkg::ERR_W;
  localparam int DW = lfpd_pkg::DRIVE_W;

  logic signed [EW-1:0]                   err;
  logic signed [lfpd_pkg::DIFF_W-1:0]     diff;
  logic signed [lfpd_pkg::DERIV_W-1:0]    deriv;
  logic signed [DW-1:0]                   p_term;
  logic signed [DW-1:0]                   d_term;
  logic signed [DW-1:0]                   drive;
  logic [DW-1:0]                          mag;

  always_comb begin
    err    = {cfg.target[lfpd_pkg::POS_W-1], cfg.target} - {pos[lfpd_pkg::POS_W-1], pos};
    diff   = {err[EW-1], err} - {last_err[EW-1], last_err};
    deriv  = lfpd_pkg::div10(diff);
    p_term = $signed({{(DW-lfpd_pkg::GAIN_W){1'b0}}, cfg.prop}) *
             $signed({{(DW-EW){err[EW-1]}}, err});
    d_term = $signed({{(DW-lfpd_pkg::GAIN_W){1'b0}}, cfg.deriv}) *
             $signed({{(DW-lfpd_pkg::DERIV_W){deriv[lfpd_pkg::DERIV_W-1]}}, deriv});
    drive  = p_term + d_term;
    mag    = drive[DW-1] ? DW'(-drive) : DW'(drive);

    law.err      = err;
    law.delta    = {{(lfpd_pkg::CALC_W-DW-1){1'b0}}, mag, 1'b0};  // times two
    law.drive_nz = |drive;
  end

endmodule

// ----- rtl/lfpd_steer.sv -----
// ---------------------------------------------------------------------------
// lfpd_steer
// Steering state: base speeds, duty registers and the previous error.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfpd_steer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                update,
  input  logic signed [lfpd_pkg::POS_W-1:0]   pos,
  input  lfpd_pkg::law_t                      law,
  output logic signed [lfpd_pkg::ERR_W-1:0]   last_err,
  output logic [lfpd_pkg::DUTY_BITS-1:0]      left_duty,
  output logic [lfpd_pkg::DUTY_BITS-1:0]      right_duty
);

  localparam int CW = lfpd_pkg::CALC_W;
  localparam int BW = lfpd_pkg::BASE_W;
  localparam int NB = lfpd_pkg::DUTY_BITS;

  logic [BW-1:0] left_base;
  logic [BW-1:0] right_base;
  logic [CW-1:0] left_calc;
  logic [CW-1:0] right_calc;
  logic [NB-1:0] turn_duty;

  assign left_calc  = {{(CW-BW){1'b0}}, left_base}  - law.delta;
  assign right_calc = {{(CW-BW){1'b0}}, right_base} - law.delta;
  assign turn_duty  = {{(NB-BW){1'b0}}, lfpd_pkg::TURN_SPEED};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err   <= '0;
      left_base  <= lfpd_pkg::BASE_RESET;
      right_base <= lfpd_pkg::BASE_RESET;
      left_duty  <= '0;
      right_duty <= '0;
    end else if (update) begin
      last_err <= law.err;
      priority if (pos[lfpd_pkg::POS_W-1]) begin
        // line left of center: slow the left wheel
        left_duty  <= left_calc[NB-1:0];
        right_base <= lfpd_pkg::TURN_SPEED;
        right_duty <= turn_duty;
      end else if (pos != '0) begin
        if (law.drive_nz) begin
          right_duty <= right_calc[NB-1:0];
        end
        left_base <= lfpd_pkg::TURN_SPEED;
        left_duty <= turn_duty;
      end else begin
        left_base  <= lfpd_pkg::TURN_SPEED;
        right_base <= lfpd_pkg::TURN_SPEED;
        left_duty  <= turn_duty;
        right_duty <= turn_duty;
      end
    end
  end

endmodule

// ----- rtl/line_follow_pd_steering_core.sv -----
// ---------------------------------------------------------------------------
// line_follow_pd_steering_core
// PD line-following controller with differential steering, top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
// Usage:
//  - sample: one signed line position per beat (negative = left of center).
//  - result: one beat per sample, holding the low 8 bits of the left and
//    right duty registers after that sample was applied.
//  - cfg_we/cfg_index/cfg_data: write setpoint (0), Kp (1), Kd (2) while the
//    core is idle; unmapped indexes are dropped.
// Path: from the sample beat through the input register, then the control law
//   into the duty registers, which drive the result beat.
// Throughput: one sample per cycle while results are taken. The control law,
//   the state update and the duty registers all sit in one stage, so each
//   sample sees the state left by the one before it without any bypass.
// Reset (rst, synchronous): both stages empty, previous error 0, bases 80,
//   duties 0, setpoint 0, Kp 3, Kd 20.
// Stall: while the result is held (valid, not ready) the duty stage stays
//   frozen; the input register still takes one more sample, then ready drops.
// ---------------------------------------------------------------------------

`include "line_follow_pd_steering_core_assert.svh"

module line_follow_pd_steering_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  lfpd_in_if.sink                           sample,
  lfpd_out_if.source                        result
);

  lfpd_pkg::cfg_t                          cfg;
  lfpd_pkg::law_t                          law;
  logic signed [lfpd_pkg::POS_W-1:0]       s1_pos;
  logic                                    s1_valid;
  logic                                    res_valid;
  logic                                    advance;
  logic                                    accept;
  logic signed [lfpd_pkg::ERR_W-1:0]       last_err;
  logic [lfpd_pkg::DUTY_BITS-1:0]          left_duty;
  logic [lfpd_pkg::DUTY_BITS-1:0]          right_duty;

  // Stage 1 moves into the duty stage whenever the result slot is free or
  // being drained this cycle.
  assign advance      = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || advance;
  assign accept       = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept)       s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;

      if (advance)           res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  // input register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos <= sample.line_position;
    end
  end

  lfpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfpd_law u_law (
    .pos      (s1_pos),
    .cfg      (cfg),
    .last_err (last_err),
    .law      (law)
  );

  // The duty registers double as the result register.
  lfpd_steer u_steer (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .pos        (s1_pos),
    .law        (law),
    .last_err   (last_err),
    .left_duty  (left_duty),
    .right_duty (right_duty)
  );

  assign result.valid      = res_valid;
  assign result.left_duty  = left_duty[lfpd_pkg::OUT_W-1:0];
  assign result.right_duty = right_duty[lfpd_pkg::OUT_W-1:0];

  `LFPD_ASSERT_IMP(a_blocked_no_take, clk, rst, s1_valid && !advance, !sample.ready,
                   "input taken while stage 1 is blocked")
  `LFPD_ASSERT_NXT(a_advance_shows, clk, rst, advance, result.valid,
                   "advanced sample did not reach the result")
  `LFPD_ASSERT_NXT(a_center_even, clk, rst, advance && (s1_pos == '0),
                   (result.left_duty == {1'b0, lfpd_pkg::TURN_SPEED}) &&
                   (result.right_duty == {1'b0, lfpd_pkg::TURN_SPEED}),
                   "centered line did not give even turn duties")

endmodule
